// ===== rtl/cpt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpt_pkg
// Shared constants for the carbon pool transformation step core.
// ----------------------------------------------------------------------------
package cpt_pkg;

	localparam int MASS_WIDTH_DEF = 48;
	localparam int RADIUS_W       = 24;
	localparam int RATE_W         = 32;
	localparam int SPLIT_W        = 17;
	localparam int KHALF_W        = 56;
	localparam int DT_W           = 40;
	localparam int CFG_DATA_W     = 56;
	localparam int CFG_IDX_W      = 3;

	// 4/3*pi in Q3.32
	localparam int VOL_C_W = 35;
	localparam logic [VOL_C_W-1:0] VOL_CONST = 35'd17990716939;

	localparam logic [SPLIT_W-1:0] SPLIT_ONE = 17'd65536;

	// divider: 80-bit denominator, quotient never above 2^48
	localparam int DEN_W = 80;
	localparam int Q_W   = 49;

	// latency of the partial-product multiplier
	localparam int MUL_LAT = 3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_UPTAKE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEATH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RESP   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPLIT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FRESH  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SLOW   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_KHALF  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_DT     = 3'd7;

endpackage

`default_nettype wire

// ===== rtl/carbon_pool_transformation_step_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// carbon_pool_transformation_step_core
// One time step of microbial growth, death, respiration and dissolution
// for a stream of independent pore balls.
// ----------------------------------------------------------------------------
// The core takes one ball word per cycle while the output word is not held
// and returns its updated masses in order, one result word per input word.
// The pipeline is fixed-depth: the ball volume and half-saturation chain
// takes four multipliers, the Michaelis-Menten ratio goes through a 49-stage
// restoring divider (one quotient bit per stage), the growth, death and split
// steps take one multiplier each, respiration and the two dissolutions one
// each, plus update stages. The whole pipe stalls as one when the output word
// is held; in_ready is low only while the last stage holds a word not taken.
// Rate factors (rate * time_step) are rebuilt in their own multipliers after
// a register write, before a word sent with the write reaches the first stage
// that needs them, so a word may follow a write at once.
// ----------------------------------------------------------------------------
module carbon_pool_transformation_step_core
	import cpt_pkg::*;
#(
	parameter int MASS_WIDTH = MASS_WIDTH_DEF
)(
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,

	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [RADIUS_W-1:0]   radius,
	input  wire logic [MASS_WIDTH-1:0] microbe_mass,
	input  wire logic [MASS_WIDTH-1:0] dissolved_mass,
	input  wire logic [MASS_WIDTH-1:0] slow_mass,
	input  wire logic [MASS_WIDTH-1:0] fresh_mass,
	input  wire logic [MASS_WIDTH-1:0] co2_mass,
	input  wire logic                  last_ball,

	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [MASS_WIDTH-1:0]      new_microbe_mass,
	output logic [MASS_WIDTH-1:0]      new_dissolved_mass,
	output logic [MASS_WIDTH-1:0]      new_slow_mass,
	output logic [MASS_WIDTH-1:0]      new_fresh_mass,
	output logic [MASS_WIDTH-1:0]      new_co2_mass,
	output logic                       sweep_done
);

	localparam int MW = MASS_WIDTH;
	localparam int L  = MUL_LAT;
	localparam int FW = 64;          // rate factor, Q8.56
	localparam int VW = 63;          // ball volume, Q39.24

	// stage plan; "feed" stages drive a multiplier, whose result is used at a later stage
	localparam int S_R3     = L;              // feed r^2 * r, then r^3 * C at 2L
	localparam int S_K      = 3 * L;          // feed khalf * V and m * Fu
	localparam int S_DEN    = 4 * L;          // K + d into divider
	localparam int S_DIV    = S_DEN + 1;      // divider input stage
	localparam int S_Q      = S_DIV + Q_W;    // quotient ready, feed a * q
	localparam int S_UPD    = S_Q + L;        // uptake applied leaving here
	localparam int S_DEAD_F = S_UPD + 1;      // feed m * Fd
	localparam int S_DEAD   = S_DEAD_F + L;   // dead amount clamped
	localparam int S_SPL_F  = S_DEAD + 1;     // feed dead * split
	localparam int S_SPL    = S_SPL_F + L;    // death applied
	localparam int S_LAST_F = S_SPL + 1;      // feed respiration, slow, fresh
	localparam int S_AMT    = S_LAST_F + L;   // amounts clamped
	localparam int S_APP1   = S_AMT + 1;      // respiration and slow applied
	localparam int S_APP2   = S_APP1 + 1;     // fresh applied
	localparam int NST      = S_APP2 + 2;

	typedef struct packed {
		logic [RADIUS_W-1:0] r;
		logic [MW-1:0]       m;
		logic [MW-1:0]       d;
		logic [MW-1:0]       sl;
		logic [MW-1:0]       fr;
		logic [MW-1:0]       co2;
		logic [MW+7:0]       a;    // (m * Fu) >> 56
		logic [MW-1:0]       x0;   // dead, then respiration amount
		logic [MW-1:0]       x1;   // slow dissolution amount
		logic [MW-1:0]       x2;   // fresh dissolution amount
		logic                last;
	} ball_t;

	function automatic logic [MW-1:0] sat_add(input logic [MW-1:0] x, input logic [MW-1:0] y);
		logic [MW:0] s;
		s = {1'b0, x} + {1'b0, y};
		return s[MW] ? '1 : s[MW-1:0];
	endfunction

	// ---------------- configuration registers ----------------
	logic [RATE_W-1:0]  uptake_rate_q, death_rate_q, resp_rate_q;
	logic [RATE_W-1:0]  fresh_rate_q, slow_rate_q;
	logic [SPLIT_W-1:0] split_q;
	logic [KHALF_W-1:0] khalf_q;
	logic [DT_W-1:0]    dt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uptake_rate_q <= '0;
			death_rate_q  <= '0;
			resp_rate_q   <= '0;
			split_q       <= '0;
			fresh_rate_q  <= '0;
			slow_rate_q   <= '0;
			khalf_q       <= '0;
			dt_q          <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_UPTAKE: uptake_rate_q <= cfg_data[RATE_W-1:0];
				REG_DEATH:  death_rate_q  <= cfg_data[RATE_W-1:0];
				REG_RESP:   resp_rate_q   <= cfg_data[RATE_W-1:0];
				REG_SPLIT:  split_q       <= cfg_data[SPLIT_W-1:0];
				REG_FRESH:  fresh_rate_q  <= cfg_data[RATE_W-1:0];
				REG_SLOW:   slow_rate_q   <= cfg_data[RATE_W-1:0];
				REG_KHALF:  khalf_q       <= cfg_data[KHALF_W-1:0];
				REG_DT:     dt_q          <= cfg_data[DT_W-1:0];
				default: ;
			endcase
		end
	end

	// split above one acts as one
	logic [SPLIT_W-1:0] split_c;
	assign split_c = (split_q > SPLIT_ONE) ? SPLIT_ONE : split_q;

	// ---------------- rate factors: (rate * dt) >> 8 ----------------
	logic [RATE_W+DT_W-1:0] fu_p, fd_p, fres_p, fs_p, ff_p;

	cpt_mul #(.AW(RATE_W), .BW(DT_W)) u_fac_up (
		.clk(clk), .en(1'b1), .a(uptake_rate_q), .b(dt_q), .p(fu_p));
	cpt_mul #(.AW(RATE_W), .BW(DT_W)) u_fac_dth (
		.clk(clk), .en(1'b1), .a(death_rate_q), .b(dt_q), .p(fd_p));
	cpt_mul #(.AW(RATE_W), .BW(DT_W)) u_fac_rsp (
		.clk(clk), .en(1'b1), .a(resp_rate_q), .b(dt_q), .p(fres_p));
	cpt_mul #(.AW(RATE_W), .BW(DT_W)) u_fac_slw (
		.clk(clk), .en(1'b1), .a(slow_rate_q), .b(dt_q), .p(fs_p));
	cpt_mul #(.AW(RATE_W), .BW(DT_W)) u_fac_frs (
		.clk(clk), .en(1'b1), .a(fresh_rate_q), .b(dt_q), .p(ff_p));

	logic [FW-1:0] f_up, f_dth, f_rsp, f_slw, f_frs;
	assign f_up  = fu_p[RATE_W+DT_W-1:8];
	assign f_dth = fd_p[RATE_W+DT_W-1:8];
	assign f_rsp = fres_p[RATE_W+DT_W-1:8];
	assign f_slw = fs_p[RATE_W+DT_W-1:8];
	assign f_frs = ff_p[RATE_W+DT_W-1:8];

	// ---------------- pipeline control ----------------
	// whole pipe advances together; it holds only when the output word waits
	logic           en;
	logic [NST-1:0] vld_s;
	ball_t          ball_s [NST];
	ball_t          nxt    [1:NST-1];

	assign en       = !vld_s[NST-1] || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NST-2:0], in_valid};
		end
	end

	// ---------------- volume and half-saturation chain ----------------
	logic [2*RADIUS_W-1:0]         r2_p;
	logic [3*RADIUS_W-1:0]         r3_p;
	logic [3*RADIUS_W+VOL_C_W-1:0] vol_p;
	logic [KHALF_W+VW-1:0]         kh_p;
	logic [MW+FW-1:0]              au_p;

	cpt_mul #(.AW(RADIUS_W), .BW(RADIUS_W)) u_mul_r2 (
		.clk(clk), .en(en), .a(ball_s[0].r), .b(ball_s[0].r), .p(r2_p));
	cpt_mul #(.AW(2*RADIUS_W), .BW(RADIUS_W)) u_mul_r3 (
		.clk(clk), .en(en), .a(r2_p), .b(ball_s[S_R3].r), .p(r3_p));
	cpt_mul #(.AW(3*RADIUS_W), .BW(VOL_C_W)) u_mul_vol (
		.clk(clk), .en(en), .a(r3_p), .b(VOL_CONST), .p(vol_p));
	cpt_mul #(.AW(KHALF_W), .BW(VW)) u_mul_k (
		.clk(clk), .en(en), .a(khalf_q), .b(vol_p[3*RADIUS_W+VOL_C_W-1:44]), .p(kh_p));
	cpt_mul #(.AW(MW), .BW(FW)) u_mul_au (
		.clk(clk), .en(en), .a(ball_s[S_K].m), .b(f_up), .p(au_p));

	// denominator K + d, registered ahead of the divider
	logic [DEN_W-1:0] den_s;

	always_ff @(posedge clk) begin
		if (en) begin
			den_s <= DEN_W'(kh_p[KHALF_W+VW-1:40]) + DEN_W'(ball_s[S_DEN].d);
		end
	end

	logic [Q_W-1:0] quo;

	cpt_div #(.NW(MW)) u_div (
		.clk(clk), .en(en), .num(ball_s[S_DIV].d), .den(den_s), .quo(quo));

	// ---------------- growth, death, respiration, dissolution ----------------
	logic [MW+8+Q_W-1:0] up_p;
	logic [MW+FW-1:0]    dd_p, rs_p, sw_p, fw_p;
	logic [MW+SPLIT_W-1:0] sp_p;

	cpt_mul #(.AW(MW+8), .BW(Q_W)) u_mul_up (
		.clk(clk), .en(en), .a(ball_s[S_Q].a), .b(quo), .p(up_p));
	cpt_mul #(.AW(MW), .BW(FW)) u_mul_dth (
		.clk(clk), .en(en), .a(ball_s[S_DEAD_F].m), .b(f_dth), .p(dd_p));
	cpt_mul #(.AW(MW), .BW(SPLIT_W)) u_mul_spl (
		.clk(clk), .en(en), .a(ball_s[S_SPL_F].x0), .b(split_c), .p(sp_p));
	cpt_mul #(.AW(MW), .BW(FW)) u_mul_rsp (
		.clk(clk), .en(en), .a(ball_s[S_LAST_F].m), .b(f_rsp), .p(rs_p));
	cpt_mul #(.AW(MW), .BW(FW)) u_mul_slw (
		.clk(clk), .en(en), .a(ball_s[S_LAST_F].sl), .b(f_slw), .p(sw_p));
	cpt_mul #(.AW(MW), .BW(FW)) u_mul_frs (
		.clk(clk), .en(en), .a(ball_s[S_LAST_F].fr), .b(f_frs), .p(fw_p));

	logic [MW+8:0] up_amt;
	logic [MW+7:0] dead_amt, rsp_amt, slw_amt, frs_amt;
	logic [MW-1:0] up_t, to_dis;

	assign up_amt   = up_p[MW+8+Q_W-1:48];
	assign dead_amt = dd_p[MW+FW-1:56];
	assign rsp_amt  = rs_p[MW+FW-1:56];
	assign slw_amt  = sw_p[MW+FW-1:56];
	assign frs_amt  = fw_p[MW+FW-1:56];
	// uptake never takes more than the dissolved pool
	assign up_t     = (up_amt < (MW+9)'(ball_s[S_UPD].d)) ? MW'(up_amt) : ball_s[S_UPD].d;
	// dissolved share of the dead never exceeds the dead amount
	assign to_dis   = MW'(sp_p[MW+SPLIT_W-1:16]);

	always_comb begin
		for (int k = 1; k < NST; k++) begin
			nxt[k] = ball_s[k-1];
			if (k == S_DIV) begin
				nxt[k].a = au_p[MW+FW-1:56];
			end
			if (k == S_UPD + 1) begin
				nxt[k].m = sat_add(ball_s[k-1].m, up_t);
				nxt[k].d = ball_s[k-1].d - up_t;
			end
			if (k == S_DEAD + 1) begin
				nxt[k].x0 = (dead_amt < (MW+8)'(ball_s[k-1].m)) ?
					MW'(dead_amt) : ball_s[k-1].m;
			end
			if (k == S_SPL + 1) begin
				nxt[k].m  = ball_s[k-1].m - ball_s[k-1].x0;
				nxt[k].d  = sat_add(ball_s[k-1].d, to_dis);
				nxt[k].sl = sat_add(ball_s[k-1].sl, ball_s[k-1].x0 - to_dis);
			end
			if (k == S_AMT + 1) begin
				nxt[k].x0 = (rsp_amt < (MW+8)'(ball_s[k-1].m)) ?
					MW'(rsp_amt) : ball_s[k-1].m;
				nxt[k].x1 = (slw_amt < (MW+8)'(ball_s[k-1].sl)) ?
					MW'(slw_amt) : ball_s[k-1].sl;
				nxt[k].x2 = (frs_amt < (MW+8)'(ball_s[k-1].fr)) ?
					MW'(frs_amt) : ball_s[k-1].fr;
			end
			if (k == S_APP1 + 1) begin
				nxt[k].m   = ball_s[k-1].m - ball_s[k-1].x0;
				nxt[k].co2 = sat_add(ball_s[k-1].co2, ball_s[k-1].x0);
				nxt[k].sl  = ball_s[k-1].sl - ball_s[k-1].x1;
				nxt[k].d   = sat_add(ball_s[k-1].d, ball_s[k-1].x1);
			end
			if (k == S_APP2 + 1) begin
				nxt[k].d  = sat_add(ball_s[k-1].d, ball_s[k-1].x2);
				nxt[k].fr = ball_s[k-1].fr - ball_s[k-1].x2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ball_s[0].r    <= radius;
			ball_s[0].m    <= microbe_mass;
			ball_s[0].d    <= dissolved_mass;
			ball_s[0].sl   <= slow_mass;
			ball_s[0].fr   <= fresh_mass;
			ball_s[0].co2  <= co2_mass;
			ball_s[0].a    <= '0;
			ball_s[0].x0   <= '0;
			ball_s[0].x1   <= '0;
			ball_s[0].x2   <= '0;
			ball_s[0].last <= last_ball;
			for (int k = 1; k < NST; k++)
				ball_s[k] <= nxt[k];
		end
	end

	// ---------------- output word ----------------
	assign out_valid          = vld_s[NST-1];
	assign new_microbe_mass   = ball_s[NST-1].m;
	assign new_dissolved_mass = ball_s[NST-1].d;
	assign new_slow_mass      = ball_s[NST-1].sl;
	assign new_fresh_mass     = ball_s[NST-1].fr;
	assign new_co2_mass       = ball_s[NST-1].co2;
	assign sweep_done         = ball_s[NST-1].last;

	// ---------------- assertions ----------------
	// Michaelis-Menten ratio is at most one when dissolved matter is present
	a_ratio_le_one: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[S_Q] && (ball_s[S_Q].d != '0)) |-> (quo <= (Q_W'(1) << (Q_W - 1))))
		else $error("uptake ratio above one");

	// uptake never grows the dissolved pool
	a_uptake_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(en && vld_s[S_UPD]) |=> (ball_s[S_UPD+1].d <= $past(ball_s[S_UPD].d)))
		else $error("uptake increased dissolved matter");

	// fresh matter only dissolves away
	a_fresh_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(en && vld_s[S_APP2]) |=> (ball_s[S_APP2+1].fr <= $past(ball_s[S_APP2].fr)))
		else $error("fresh matter grew");

endmodule

`default_nettype wire

// ===== rtl/cpt_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpt_mul
// Unsigned multiplier built from 32x32 partial products, three stages.
// ----------------------------------------------------------------------------
module cpt_mul
	import cpt_pkg::*;
#(
	parameter int AW = 32,
	parameter int BW = 32
)(
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [AW-1:0]    a,
	input  wire logic [BW-1:0]    b,
	output logic      [AW+BW-1:0] p
);

	localparam int NA = (AW + 31) / 32;
	localparam int NB = (BW + 31) / 32;
	localparam int RW = 32 * NB + 32;
	localparam int PW = 32 * NA + 32 * NB;

	logic [32*NA-1:0] ax;
	logic [32*NB-1:0] bx;
	logic [63:0]      pp_s1 [NA][NB];
	logic [RW-1:0]    row_c [NA];
	logic [RW-1:0]    row_s2 [NA];
	logic [PW-1:0]    sum_c;
	logic [PW-1:0]    sum_s3;

	assign ax = (32*NA)'(a);
	assign bx = (32*NB)'(b);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NA; i++)
				for (int j = 0; j < NB; j++)
					pp_s1[i][j] <= 64'(ax[32*i +: 32]) * 64'(bx[32*j +: 32]);
		end
	end

	always_comb begin
		for (int i = 0; i < NA; i++) begin
			row_c[i] = '0;
			for (int j = 0; j < NB; j++)
				row_c[i] = row_c[i] + (RW'(pp_s1[i][j]) << (32 * j));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NA; i++)
				row_s2[i] <= row_c[i];
		end
	end

	always_comb begin
		sum_c = '0;
		for (int i = 0; i < NA; i++)
			sum_c = sum_c + (PW'(row_s2[i]) << (32 * i));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3 <= sum_c;
		end
	end

	assign p = sum_s3[AW+BW-1:0];

endmodule

`default_nettype wire

// ===== rtl/cpt_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpt_div
// Pipelined restoring divider for (num << 48) / den, one quotient bit a stage.
// ----------------------------------------------------------------------------
module cpt_div
	import cpt_pkg::*;
#(
	parameter int NW = MASS_WIDTH_DEF
)(
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [NW-1:0]    num,
	input  wire logic [DEN_W-1:0] den,
	output logic      [Q_W-1:0]   quo
);

	logic [DEN_W-1:0] rem_s [Q_W];
	logic [DEN_W-1:0] den_s [Q_W];
	logic [Q_W-1:0]   q_s   [Q_W];

	for (genvar k = 0; k < Q_W; k++) begin : g_step
		logic [DEN_W-1:0] rem_in;
		logic [DEN_W-1:0] den_in;
		logic [Q_W-1:0]   q_in;
		logic             bit_in;
		logic [DEN_W:0]   trial;
		logic [DEN_W:0]   diff;

		if (k == 0) begin : g_first
			// top quotient bits are zero since num never exceeds den
			assign rem_in = DEN_W'(num >> 1);
			assign den_in = den;
			assign q_in   = '0;
			assign bit_in = num[0];
		end else begin : g_rest
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
			assign q_in   = q_s[k-1];
			assign bit_in = 1'b0;
		end

		assign trial = {rem_in, bit_in};
		assign diff  = trial - {1'b0, den_in};

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[k] <= den_in;
				if (!diff[DEN_W]) begin
					rem_s[k] <= diff[DEN_W-1:0];
					q_s[k]   <= {q_in[Q_W-2:0], 1'b1};
				end else begin
					rem_s[k] <= trial[DEN_W-1:0];
					q_s[k]   <= {q_in[Q_W-2:0], 1'b0};
				end
			end
		end
	end

	assign quo = q_s[Q_W-1];

endmodule

`default_nettype wire
